// File: sv/lsf_pkg.sv
// Shared constants, codes, control structs and fade arithmetic of the LED strip fade engine.
package lsf_pkg;

	// String length and field widths.
	localparam int PIXELS     = 42;
	localparam int IDX_W      = 6;
	localparam int CH_W       = 8;
	localparam int WORD_W     = 3 * CH_W;
	localparam int KIND_W     = 3;
	localparam int SEG_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int CNT_W      = IDX_W + 1;

	// Register reset values.
	localparam logic [CH_W-1:0]  FADE_STEP_RST  = 8'd3;
	localparam logic [SEG_W-1:0] SEG1_FIRST_RST = 6'd0;
	localparam logic [SEG_W-1:0] SEG1_LAST_RST  = 6'd5;
	localparam logic [SEG_W-1:0] SEG2_FIRST_RST = 6'd6;
	localparam logic [SEG_W-1:0] SEG2_LAST_RST  = 6'd15;
	localparam logic [SEG_W-1:0] SEG3_FIRST_RST = 6'd16;
	localparam logic [SEG_W-1:0] SEG3_LAST_RST  = 6'd41;

	// Segment numbers for a fill command.
	localparam logic [IDX_W-1:0] SEG_ALL   = 6'd0;
	localparam logic [IDX_W-1:0] SEG_ONE   = 6'd1;
	localparam logic [IDX_W-1:0] SEG_TWO   = 6'd2;
	localparam logic [IDX_W-1:0] SEG_THREE = 6'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_PIXEL  = 3'd0,
		KIND_SET_TARGET = 3'd1,
		KIND_FILL       = 3'd2,
		KIND_DRAW       = 3'd3,
		KIND_CLEAR      = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_STEP  = 3'd0,
		CFG_SEG1_FIRST = 3'd1,
		CFG_SEG1_LAST  = 3'd2,
		CFG_SEG2_FIRST = 3'd3,
		CFG_SEG2_LAST  = 3'd4,
		CFG_SEG3_FIRST = 3'd5,
		CFG_SEG3_LAST  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_WRITE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic set_cur;
		logic set_tgt;
		logic fill_init;
		logic fill_step;
		logic pass_init;
		logic clr_vld;
		logic rd;
		logic wr_pix;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_go;
		logic last_pix;
		logic out_free;
	} sts_t;

	// Moves one channel toward its target by at most step.
	function automatic logic [CH_W-1:0] fade_chan(
		input logic [CH_W-1:0] cur,
		input logic [CH_W-1:0] dst,
		input logic [CH_W-1:0] step
	);
		logic [CH_W-1:0] gap;
		logic [CH_W-1:0] res;
		if (dst > cur) begin
			gap = dst - cur;
			res = (gap > step) ? cur + step : dst;
		end else begin
			gap = cur - dst;
			res = (gap > step) ? cur - step : dst;
		end
		return res;
	endfunction

endpackage

// File: sv/lsf_if.sv
// Command, pixel output and configuration channel interfaces.
interface lsf_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [lsf_pkg::KIND_W-1:0]  kind;
	logic [lsf_pkg::IDX_W-1:0]   index;
	logic [lsf_pkg::CH_W-1:0]    red;
	logic [lsf_pkg::CH_W-1:0]    green;
	logic [lsf_pkg::CH_W-1:0]    blue;

	modport source(output valid, kind, index, red, green, blue, input ready);
	modport sink(input valid, kind, index, red, green, blue, output ready);
endinterface

interface lsf_pix_if;
	logic                        valid;
	logic                        ready;
	logic [lsf_pkg::WORD_W-1:0]  pixel_word;
	logic                        last;
	logic                        fade_pending;

	modport source(output valid, pixel_word, last, fade_pending, input ready);
	modport sink(input valid, pixel_word, last, fade_pending, output ready);
endinterface

interface lsf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lsf_pkg::CFG_IDX_W-1:0]   index;
	logic [lsf_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/led_strip_fade_frame_engine_core.sv
// Top level of the LED strip fade engine: controller, datapath and channel hookup.
// Set pixel and set target write the buffers straight from idle; a fill writes its colour to
// each target of its segment in turn. Draw and clear walk the string through one read and one
// write memory port, one read state and one write state per pixel, pixels never overlapping.
// Commands are handled one at a time; a held output word stalls the sweep, not the buffers.
// Reset clears both colour buffers at once through per-pixel valid bits and loads the
// register defaults; no clearing pass is needed.
module led_strip_fade_frame_engine_core (
	input  logic     clk,
	input  logic     arst_n,
	lsf_cmd_if.sink  cmd,
	lsf_pix_if.source pix,
	lsf_cfg_if.sink  cfg
);

	lsf_pkg::ctl_t ctl;
	lsf_pkg::sts_t sts;

	// The controller accepts a command transaction only when idle, then runs the
	// fill or frame sweep for it, if any, before taking the next one.
	lsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_kind  (cmd.kind),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// The datapath owns both colour buffers, the registers and the output word.
	lsf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd_index   (cmd.index),
		.cmd_red     (cmd.red),
		.cmd_green   (cmd.green),
		.cmd_blue    (cmd.blue),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.pix_ready   (pix.ready),
		.pix_valid   (pix.valid),
		.pix_word    (pix.pixel_word),
		.pix_last    (pix.last),
		.pix_pending (pix.fade_pending)
	);

	// Register writes never stall, so every configuration
	// transaction is taken as soon as it is offered.
	assign cfg.ready = 1'b1;

endmodule

// File: sv/lsf_ctrl.sv
// Command sequencer: decodes transactions and steps fill and frame sweeps.
module lsf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic [lsf_pkg::KIND_W-1:0] cmd_kind,
	output logic                       cmd_ready,
	input  lsf_pkg::sts_t              sts,
	output lsf_pkg::ctl_t              ctl
);

	lsf_pkg::state_t state_q;
	lsf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			lsf_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (lsf_pkg::kind_t'(cmd_kind))
						lsf_pkg::KIND_SET_PIXEL: begin
							ctl.set_cur = 1'b1;
							ctl.set_tgt = 1'b1;
						end
						lsf_pkg::KIND_SET_TARGET: begin
							ctl.set_tgt = 1'b1;
						end
						lsf_pkg::KIND_FILL: begin
							ctl.fill_init = 1'b1;
							state_d       = lsf_pkg::ST_FILL;
						end
						lsf_pkg::KIND_DRAW: begin
							ctl.pass_init = 1'b1;
							state_d       = lsf_pkg::ST_READ;
						end
						lsf_pkg::KIND_CLEAR: begin
							ctl.pass_init = 1'b1;
							ctl.clr_vld   = 1'b1;
							state_d       = lsf_pkg::ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			lsf_pkg::ST_FILL: begin
				if (sts.fill_go) begin
					ctl.fill_step = 1'b1;
				end else begin
					state_d = lsf_pkg::ST_IDLE;
				end
			end
			lsf_pkg::ST_READ: begin
				// Only fetch a pixel once the output register will have room for it.
				if (sts.out_free) begin
					ctl.rd  = 1'b1;
					state_d = lsf_pkg::ST_WRITE;
				end
			end
			lsf_pkg::ST_WRITE: begin
				ctl.wr_pix = 1'b1;
				state_d    = sts.last_pix ? lsf_pkg::ST_IDLE : lsf_pkg::ST_READ;
			end
		endcase
	end

endmodule

// File: sv/lsf_datapath.sv
// Colour buffers, configuration registers, fade arithmetic and output register.
module lsf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsf_pkg::ctl_t                  ctl,
	output lsf_pkg::sts_t                  sts,
	input  logic [lsf_pkg::IDX_W-1:0]      cmd_index,
	input  logic [lsf_pkg::CH_W-1:0]       cmd_red,
	input  logic [lsf_pkg::CH_W-1:0]       cmd_green,
	input  logic [lsf_pkg::CH_W-1:0]       cmd_blue,
	input  logic                           cfg_valid,
	input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pix_ready,
	output logic                           pix_valid,
	output logic [lsf_pkg::WORD_W-1:0]     pix_word,
	output logic                           pix_last,
	output logic                           pix_pending
);

	localparam int AW = lsf_pkg::ADDR_W;
	localparam int CW = lsf_pkg::CNT_W;
	localparam int WW = lsf_pkg::WORD_W;
	localparam int SW = lsf_pkg::SEG_W;
	localparam int HW = lsf_pkg::CH_W;

	// Configuration registers.
	logic [HW-1:0] fade_step_q;
	logic [SW-1:0] seg1_first_q, seg1_last_q;
	logic [SW-1:0] seg2_first_q, seg2_last_q;
	logic [SW-1:0] seg3_first_q, seg3_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q  <= lsf_pkg::FADE_STEP_RST;
			seg1_first_q <= lsf_pkg::SEG1_FIRST_RST;
			seg1_last_q  <= lsf_pkg::SEG1_LAST_RST;
			seg2_first_q <= lsf_pkg::SEG2_FIRST_RST;
			seg2_last_q  <= lsf_pkg::SEG2_LAST_RST;
			seg3_first_q <= lsf_pkg::SEG3_FIRST_RST;
			seg3_last_q  <= lsf_pkg::SEG3_LAST_RST;
		end else if (cfg_valid) begin
			unique case (lsf_pkg::cfg_reg_t'(cfg_index))
				lsf_pkg::CFG_FADE_STEP:  fade_step_q  <= cfg_data;
				lsf_pkg::CFG_SEG1_FIRST: seg1_first_q <= cfg_data[SW-1:0];
				lsf_pkg::CFG_SEG1_LAST:  seg1_last_q  <= cfg_data[SW-1:0];
				lsf_pkg::CFG_SEG2_FIRST: seg2_first_q <= cfg_data[SW-1:0];
				lsf_pkg::CFG_SEG2_LAST:  seg2_last_q  <= cfg_data[SW-1:0];
				lsf_pkg::CFG_SEG3_FIRST: seg3_first_q <= cfg_data[SW-1:0];
				lsf_pkg::CFG_SEG3_LAST:  seg3_last_q  <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Command payload decode.
	logic [WW-1:0] cmd_colr;
	logic [AW-1:0] cmd_addr;
	logic          set_ok;
	logic [CW-1:0] seg_first;
	logic [SW-1:0] seg_last;

	assign cmd_colr = {cmd_green, cmd_red, cmd_blue};
	assign cmd_addr = cmd_index[AW-1:0];
	assign set_ok   = {1'b0, cmd_index} < CW'(lsf_pkg::PIXELS);

	// An unknown segment number yields an empty range.
	always_comb begin
		unique case (cmd_index)
			lsf_pkg::SEG_ALL: begin
				seg_first = '0;
				seg_last  = SW'(lsf_pkg::PIXELS - 1);
			end
			lsf_pkg::SEG_ONE: begin
				seg_first = {1'b0, seg1_first_q};
				seg_last  = seg1_last_q;
			end
			lsf_pkg::SEG_TWO: begin
				seg_first = {1'b0, seg2_first_q};
				seg_last  = seg2_last_q;
			end
			lsf_pkg::SEG_THREE: begin
				seg_first = {1'b0, seg3_first_q};
				seg_last  = seg3_last_q;
			end
			default: begin
				seg_first = CW'(1);
				seg_last  = '0;
			end
		endcase
	end

	// Sweep counter, fill bounds and the pass-wide change flag.
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] fill_last_q;
	logic          pend_q;
	logic          pend_next;
	logic [AW-1:0] addr;

	assign addr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fill_last_q <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (ctl.fill_init) begin
				cnt_q       <= seg_first;
				fill_last_q <= seg_last;
			end else if (ctl.pass_init) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end else if (ctl.fill_step) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.wr_pix) begin
				cnt_q  <= cnt_q + CW'(1);
				pend_q <= pend_next;
			end
		end
	end

	logic [WW-1:0] colr_q;

	always_ff @(posedge clk) begin
		if (ctl.fill_init) begin
			colr_q <= cmd_colr;
		end
	end

	// Current and target colour memories; a clear valid bit reads as zero.
	logic [WW-1:0]           cur_mem [lsf_pkg::PIXELS];
	logic [WW-1:0]           tgt_mem [lsf_pkg::PIXELS];
	logic [lsf_pkg::PIXELS-1:0] cur_vld_q;
	logic [lsf_pkg::PIXELS-1:0] tgt_vld_q;
	logic [WW-1:0]           cur_rd_q, tgt_rd_q;
	logic                    cur_rv_q, tgt_rv_q;

	logic          cur_we, tgt_we;
	logic [AW-1:0] cur_wa, tgt_wa;
	logic [WW-1:0] cur_wd, tgt_wd;
	logic [WW-1:0] new_word;

	assign cur_we = (ctl.set_cur && set_ok) || ctl.wr_pix;
	assign cur_wa = ctl.wr_pix ? addr : cmd_addr;
	assign cur_wd = ctl.wr_pix ? new_word : cmd_colr;
	assign tgt_we = (ctl.set_tgt && set_ok) || ctl.fill_step;
	assign tgt_wa = ctl.fill_step ? addr : cmd_addr;
	assign tgt_wd = ctl.fill_step ? colr_q : cmd_colr;

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		if (tgt_we) begin
			tgt_mem[tgt_wa] <= tgt_wd;
		end
		if (ctl.rd) begin
			cur_rd_q <= cur_mem[addr];
			tgt_rd_q <= tgt_mem[addr];
			cur_rv_q <= cur_vld_q[addr];
			tgt_rv_q <= tgt_vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= '0;
			tgt_vld_q <= '0;
		end else if (ctl.clr_vld) begin
			cur_vld_q <= '0;
			tgt_vld_q <= '0;
		end else begin
			if (cur_we) begin
				cur_vld_q[cur_wa] <= 1'b1;
			end
			if (tgt_we) begin
				tgt_vld_q[tgt_wa] <= 1'b1;
			end
		end
	end

	// Fade one pixel: each channel moves toward its target.
	logic [WW-1:0] cur_px, tgt_px;
	logic [HW-1:0] step;

	assign cur_px    = cur_rv_q ? cur_rd_q : '0;
	assign tgt_px    = tgt_rv_q ? tgt_rd_q : '0;
	assign step      = (fade_step_q == '0) ? HW'(1) : fade_step_q;
	assign pend_next = pend_q || (cur_px != tgt_px);
	assign new_word  = {
		lsf_pkg::fade_chan(cur_px[3*HW-1:2*HW], tgt_px[3*HW-1:2*HW], step),
		lsf_pkg::fade_chan(cur_px[2*HW-1:HW], tgt_px[2*HW-1:HW], step),
		lsf_pkg::fade_chan(cur_px[HW-1:0], tgt_px[HW-1:0], step)
	};

	// Output register.
	logic          out_vld_q;
	logic [WW-1:0] out_word_q;
	logic          out_last_q;
	logic          out_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.wr_pix) begin
			out_vld_q <= 1'b1;
		end else if (pix_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_pix) begin
			out_word_q <= new_word;
			out_last_q <= sts.last_pix;
			out_pend_q <= sts.last_pix && pend_next;
		end
	end

	assign pix_valid   = out_vld_q;
	assign pix_word    = out_word_q;
	assign pix_last    = out_last_q;
	assign pix_pending = out_pend_q;

	assign sts.fill_go  = (cnt_q <= {1'b0, fill_last_q}) && (cnt_q < CW'(lsf_pkg::PIXELS));
	assign sts.last_pix = cnt_q == CW'(lsf_pkg::PIXELS - 1);
	assign sts.out_free = !out_vld_q || pix_ready;

endmodule
